@@ sv/ofc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofc_pkg: shared types and constants for the file-transfer checksum
// Accumulator start value, byte count ceiling, register map and the
// word passed from the accumulate stage to the fold stage.
// ----------------------------------------------------------------------------
package ofc_pkg;

  localparam logic [31:0] ACC_START = 32'h0000_FFFF;
  localparam logic [30:0] COUNT_MAX = 31'h7FFF_FFFF;

  // register indexes (byte address bit 2)
  localparam logic REG_LIMIT_ENABLE = 1'b0;
  localparam logic REG_BYTE_LIMIT   = 1'b1;

  // finished accumulator handed to the fold stage
  typedef struct packed {
    logic        valid;
    logic [31:0] acc;
  } fin_t;

  // two end-around folds, result placed in the upper half
  function automatic logic [31:0] fold_checksum(input logic [31:0] a);
    logic [16:0] s1;
    logic [16:0] s2;
    s1 = {1'b0, a[15:0]} + {1'b0, a[31:16]};
    s2 = {1'b0, s1[15:0]} + {16'h0000, s1[16]};
    return {s2[15:0], 16'h0000};
  endfunction

endpackage

@@ sv/ofc_accum.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofc_accum: per-byte accumulate stage
// Pairs bytes into words high byte first, subtracts each word with the
// extra borrow, applies the byte limit and hands the final accumulator
// of each file to the fold stage.
// ----------------------------------------------------------------------------
module ofc_accum import ofc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        take,
  input  logic [7:0]  data_byte,
  input  logic        byte_valid,
  input  logic        is_last,
  input  logic        limit_enable,
  input  logic [30:0] byte_limit,
  input  logic        fin_ready,
  output fin_t        fin
);

  logic [31:0] acc_r;
  logic [7:0]  held_r;
  logic        pending_r;
  logic [30:0] count_r;
  logic        fin_valid_r;
  logic [31:0] fin_acc_r;

  logic        allowed;
  logic        pair;
  logic        odd_end;
  logic        do_sub;
  logic [15:0] word;
  logic [32:0] diff;
  logic [31:0] acc_sub;
  logic [31:0] acc_nxt;

  // byte admission and word selection
  always_comb begin
    allowed = byte_valid && (!limit_enable || (count_r < byte_limit));
    pair    = allowed && pending_r;
    odd_end = is_last && (allowed ? !pending_r : pending_r);
    do_sub  = pair || odd_end;
    priority if (pair) begin
      word = {held_r, data_byte};
    end else if (allowed) begin
      word = {data_byte, 8'h00};
    end else begin
      word = {held_r, 8'h00};
    end
  end

  // subtract with one more on wrap
  always_comb begin
    diff    = {1'b0, acc_r} - {17'h0_0000, word};
    acc_sub = diff[31:0] - {31'h0000_0000, diff[32]};
    acc_nxt = do_sub ? acc_sub : acc_r;
  end

  // file state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= ACC_START;
      held_r    <= 8'h00;
      pending_r <= 1'b0;
      count_r   <= '0;
    end else if (take) begin
      if (is_last) begin
        acc_r     <= ACC_START;
        held_r    <= 8'h00;
        pending_r <= 1'b0;
        count_r   <= '0;
      end else begin
        acc_r <= acc_nxt;
        if (allowed) begin
          if (pending_r) begin
            held_r    <= 8'h00;
            pending_r <= 1'b0;
          end else begin
            held_r    <= data_byte;
            pending_r <= 1'b1;
          end
          if (count_r != COUNT_MAX) begin
            count_r <= count_r + 31'd1;
          end
        end
      end
    end
  end

  // hand-off register to the fold stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_valid_r <= 1'b0;
    end else begin
      if (fin_ready) begin
        fin_valid_r <= 1'b0;
      end
      if (take && is_last) begin
        fin_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && is_last) begin
      fin_acc_r <= acc_nxt;
    end
  end

  assign fin = '{valid: fin_valid_r, acc: fin_acc_r};

endmodule

@@ sv/oft_file_checksum.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oft_file_checksum: streaming file-transfer checksum
// Sums a byte stream as 16-bit words into a subtractive accumulator and
// emits the folded checksum at the end of each file.
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  in_*      slave      in_tvalid/tready    tdata=data_byte, tuser=byte_valid,
//                                           tlast=is_last
//  out_*     master     out_tvalid/tready   tdata=checksum_value
//  cfg_*     apb slave  psel/penable        0x0 limit_enable, 0x4 byte_limit
//
//  one byte per cycle while in_tready is high; the per-byte subtract with borrow sets the loop
//  after its last word is accepted, a checksum passes through the accumulate
//  hand-off register, then the fold stage into the output register
//  rst_n is synchronous and clears the file state, the settings and the valid bits of both registers
//  input stalls only while a finished checksum and a pending one both wait
// ----------------------------------------------------------------------------
module oft_file_checksum import ofc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] byte_valid
  input  logic        in_tlast,
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] checksum_value
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic        limit_enable_r;
  logic [30:0] byte_limit_r;
  logic        out_tvalid_r;
  logic [31:0] out_tdata_r;
  logic        fin_ready;
  logic        in_take;
  logic        cfg_wr;
  fin_t        fin;

  // configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_enable_r <= 1'b0;
      byte_limit_r   <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_LIMIT_ENABLE: limit_enable_r <= cfg_pwdata[0];
        REG_BYTE_LIMIT:   byte_limit_r   <= cfg_pwdata[30:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_LIMIT_ENABLE: cfg_prdata = {31'h0000_0000, limit_enable_r};
      REG_BYTE_LIMIT:   cfg_prdata = {1'b0, byte_limit_r};
      default:          cfg_prdata = 32'h0000_0000;
    endcase
  end

  // stream handshake
  assign fin_ready = !out_tvalid_r || out_tready;
  assign in_tready = !fin.valid || fin_ready;
  assign in_take   = in_tvalid && in_tready;

  ofc_accum u_accum (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (in_take),
    .data_byte    (in_tdata),
    .byte_valid   (in_tuser),
    .is_last      (in_tlast),
    .limit_enable (limit_enable_r),
    .byte_limit   (byte_limit_r),
    .fin_ready    (fin_ready),
    .fin          (fin)
  );

  // fold stage into the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (fin_ready) begin
      out_tvalid_r <= fin.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_ready && fin.valid) begin
      out_tdata_r <= fold_checksum(fin.acc);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // checks
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (fin.valid && out_tvalid && !out_tready))
    else $error("input stalled with room downstream");

  a_last_reaches_fold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && in_tlast) |=> fin.valid)
    else $error("end of file word lost before fold stage");

  a_fold_to_output: assert property (@(posedge clk) disable iff (!rst_n)
    (fin.valid && fin_ready) |=> out_tvalid)
    else $error("folded checksum not presented");

  a_low_half_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[15:0] == 16'h0000))
    else $error("checksum low half not zero");

endmodule

@@ sim/oft_file_checksum_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oft_file_checksum_tb: self-checking bench for the file-transfer checksum
// Streams files of random bytes, with empty markers, odd tails and byte
// limits, through the block while both stream sides stall at random. Each
// accepted word updates a software copy of the accumulator. Each checksum
// that comes out is compared with the oldest predicted checksum.
// ----------------------------------------------------------------------------

// predicted checksums and the running file state behind them
class checksum_scoreboard;
  bit        limit_on;
  bit [30:0] limit_bytes;
  bit [31:0] acc;
  bit [7:0]  hi_byte;
  bit        hi_held;
  bit [30:0] taken;
  bit [31:0] checksum_q[$];
  int        errors;

  function new();
    limit_on    = 1'b0;
    limit_bytes = '0;
    errors      = 0;
    clear_file();
  endfunction

  function void clear_file();
    acc     = 32'h0000_FFFF;
    hi_byte = '0;
    hi_held = 1'b0;
    taken   = '0;
  endfunction

  function void set_reg(logic idx, bit [31:0] v);
    if (idx == ofc_pkg::REG_LIMIT_ENABLE) begin
      limit_on = v[0];
    end else begin
      limit_bytes = v[30:0];
    end
  endfunction

  // subtract with one extra borrow on wrap
  function void sub_word(bit [15:0] w);
    bit [31:0] prior;
    prior = acc;
    acc = prior - {16'h0000, w};
    if (acc > prior) begin
      acc = acc - 32'd1;
    end
  endfunction

  // one accepted input word
  function void accept_word(bit [7:0] b, bit v, bit last);
    bit [31:0] c;
    if (v && (!limit_on || taken < limit_bytes)) begin
      if (hi_held) begin
        sub_word({hi_byte, b});
        hi_held = 1'b0;
        hi_byte = '0;
      end else begin
        hi_byte = b;
        hi_held = 1'b1;
      end
      if (taken != 31'h7FFF_FFFF) begin
        taken = taken + 31'd1;
      end
    end
    if (last) begin
      // lone high byte pairs with a zero low byte
      if (hi_held) begin
        sub_word({hi_byte, 8'h00});
      end
      c = acc;
      c = {16'h0000, c[15:0]} + {16'h0000, c[31:16]};
      c = {16'h0000, c[15:0]} + {16'h0000, c[31:16]};
      checksum_q.push_back({c[15:0], 16'h0000});
      clear_file();
    end
  endfunction

  function void check_checksum(bit [31:0] got);
    bit [31:0] want;
    if (checksum_q.size() == 0) begin
      $display("%0t unexpected checksum: expected none actual %08h", $time, got);
      errors++;
    end else begin
      want = checksum_q.pop_front();
      if (got !== want) begin
        $display("%0t checksum mismatch: expected %08h actual %08h", $time, want, got);
        errors++;
      end
    end
  endfunction

  function int pending();
    return checksum_q.size();
  endfunction
endclass

module oft_file_checksum_tb;
  import ofc_pkg::*;

  localparam int DRAIN_CYCLES = 6;
  localparam int IDLE_PCT     = 32;
  localparam int CYCLE_LIMIT  = 400000;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = '0;   // [7:0] data_byte
  logic        in_tuser    = 1'b0; // [0] byte_valid
  logic        in_tlast    = 1'b0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [31:0] out_tdata;          // [31:0] checksum_value
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [2:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  checksum_scoreboard sb = new();
  bit no_gaps   = 1'b0;
  int items_sent = 0;
  int cycles     = 0;

  oft_file_checksum u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #10 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    out_tready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // check each checksum word as it leaves
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_checksum(out_tdata);
    end
  end

  // one input word, with random idle cycles ahead of it
  task automatic send_item(input logic [7:0] b, input logic v, input logic last);
    while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= v;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    sb.accept_word(b, v, last);
    items_sent++;
  endtask

  task automatic end_burst();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  // all checksums out, then let the pipeline settle
  task automatic wait_drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [31:0] v);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= v;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // n body words, optionally closed by an end-of-file word
  task automatic send_file(input int n, input bit close);
    int i;
    for (i = 0; i < n; i++) begin
      send_item(pick_byte(), $urandom_range(0, 9) != 0, 1'b0);
    end
    if (close) begin
      send_item(pick_byte(), 1'($urandom_range(0, 1)), 1'b1);
    end
  endtask

  initial begin
    int        ph;
    int        target;
    int        len;
    bit        en;
    bit [31:0] lim;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: full sum, empty file, odd tails, empty end markers
    cfg_write(REG_LIMIT_ENABLE, 32'd0);
    cfg_write(REG_BYTE_LIMIT, 32'd0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hAB, 1'b1, 1'b0);
    send_item(8'hCD, 1'b1, 1'b0);
    send_item(8'hEF, 1'b1, 1'b1);
    send_item(8'h12, 1'b0, 1'b0);
    send_item(8'h34, 1'b1, 1'b1);
    end_burst();
    wait_drain();

    // limit of zero sums nothing
    cfg_write(REG_LIMIT_ENABLE, 32'd1);
    send_item(8'h55, 1'b1, 1'b0);
    send_item(8'h66, 1'b1, 1'b1);
    end_burst();
    wait_drain();

    // limit cuts the file after an odd byte
    cfg_write(REG_BYTE_LIMIT, 32'd3);
    send_item(8'h01, 1'b1, 1'b0);
    send_item(8'h02, 1'b1, 1'b0);
    send_item(8'h03, 1'b1, 1'b0);
    send_item(8'h04, 1'b1, 1'b0);
    send_item(8'h05, 1'b1, 1'b1);
    end_burst();
    wait_drain();

    // largest limit
    cfg_write(REG_BYTE_LIMIT, 32'h7FFF_FFFF);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h7F, 1'b1, 1'b1);
    end_burst();
    wait_drain();

    // limit change in the middle of a file
    cfg_write(REG_BYTE_LIMIT, 32'd3);
    send_item(8'h10, 1'b1, 1'b0);
    send_item(8'h20, 1'b1, 1'b0);
    end_burst();
    wait_drain();
    cfg_write(REG_LIMIT_ENABLE, 32'd0);
    send_item(8'h30, 1'b1, 1'b0);
    send_item(8'h40, 1'b1, 1'b1);

    // random phases, each with its own register setting
    for (ph = 0; ph < 6; ph++) begin
      end_burst();
      wait_drain();
      if (ph == 0) en = 1'b1;
      else if (ph == 1) en = 1'b0;
      else en = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 3))
        0:       lim = 32'd0;
        1:       lim = $urandom_range(1, 40);
        2:       lim = {1'b0, 31'($urandom)};
        default: lim = 32'h7FFF_FFFF;
      endcase
      if (ph == 0) lim = $urandom_range(1, 40);
      cfg_write(REG_LIMIT_ENABLE, {31'd0, en});
      cfg_write(REG_BYTE_LIMIT, lim);
      no_gaps = (ph == 3);
      target = items_sent + 250;
      while (items_sent < target) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 30);
        send_file(len, 1'b1);
        // sender holds off until every checksum is out
        if (ph == 1 && $urandom_range(0, 9) == 0) begin
          end_burst();
          wait_drain();
        end
      end
      // leave a file open across the next register change
      if ($urandom_range(0, 2) == 0) begin
        send_file($urandom_range(1, 9), 1'b0);
      end
    end
    no_gaps = 1'b0;
    send_file(0, 1'b1);
    end_burst();
    wait_drain();

    if (sb.pending() != 0) begin
      $display("%0t %0d checksums never arrived", $time, sb.pending());
    end
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/ofc_pkg.sv
sv/ofc_accum.sv
sv/oft_file_checksum.sv
sim/oft_file_checksum_tb.sv
